// File: hw/rtl/lpob_pkg.sv
`timescale 1ns / 1ps
package lpob_pkg;

  localparam int SCREEN_WIDTH_DEF  = 256;
  localparam int SCREEN_HEIGHT_DEF = 224;

  localparam logic [23:0] HEAT_TINT  = 24'hFF6020;
  localparam logic [23:0] WARN_TINT  = 24'hFF2810;
  localparam logic [23:0] GLOW_TINT  = 24'hFF9030;
  localparam logic [23:0] CREST_TINT = 24'hFFE080;
  localparam logic [23:0] BODY_TINT  = 24'hE03808;
  localparam logic [23:0] DEEP_TINT  = 24'h801000;

  localparam int TIER_FULL  = 48;
  localparam int WARN_RANGE = 240;
  localparam int WARN_STEP  = 60;
  localparam int WAVE_AMP   = 2;

  // x mod 97 via reciprocal: q = (x * BUB_RECIP) >> BUB_SHIFT, exact for x < 2^27
  localparam int unsigned BUB_MOD   = 97;
  localparam logic [27:0] BUB_RECIP = 28'd177112054;
  localparam int          BUB_SHIFT = 34;

  typedef enum logic [2:0] {
    KIND_NONE,
    KIND_WARN,
    KIND_CREST,
    KIND_BODY,
    KIND_GLOW
  } kind_t;

  typedef enum logic [1:0] {
    DIV3,
    DIV5,
    DIV48
  } div_t;

  typedef enum logic [2:0] {
    REG_CLIMB,
    REG_TIER,
    REG_LAVA,
    REG_FLOOR,
    REG_VIEW,
    REG_LEFT,
    REG_FRAME
  } reg_idx_t;

  typedef struct packed {
    logic               climb;
    logic [5:0]         tier;
    logic               lava;
    logic signed [23:0] floor_row;
    logic signed [23:0] view_row;
    logic [15:0]        left_col;
    logic [23:0]        frame;
  } cfg_t;

  typedef struct packed {
    kind_t              kind;
    logic [2:0]         warn_n;
    logic               deep;
    logic               d16;
    logic signed [27:0] sum;
    logic [5:0]         heat_n;
  } cls_t;

  function automatic logic [5:0] d_value(div_t d);
    case (d)
      DIV3:    d_value = 6'd3;
      DIV5:    d_value = 6'd5;
      DIV48:   d_value = 6'(TIER_FULL);
      default: d_value = 6'd5;
    endcase
  endfunction

  function automatic logic signed [2:0] wave_of(logic [3:0] i);
    logic signed [2:0] w;
    case (i)
      4'd1, 4'd2, 4'd9, 4'd10:   w = 3'sd1;
      4'd5, 4'd6, 4'd13, 4'd14:  w = -3'sd1;
      default:                   w = 3'sd0;
    endcase
    wave_of = 3'(w * 3'(WAVE_AMP));
  endfunction

endpackage

// File: hw/rtl/lpob_class.sv
`timescale 1ns / 1ps
module lpob_class #(
  parameter int SCREEN_WIDTH  = lpob_pkg::SCREEN_WIDTH_DEF,
  parameter int SCREEN_HEIGHT = lpob_pkg::SCREEN_HEIGHT_DEF
) (
  input  lpob_pkg::cfg_t cfg,
  input  logic [7:0]     col,
  input  logic [7:0]     row,
  output lpob_pkg::cls_t cls
);
  import lpob_pkg::*;

  localparam logic signed [25:0] H26 = 26'(SCREEN_HEIGHT);

  logic               offscreen;
  logic signed [25:0] surf;
  logic signed [25:0] row26;
  logic signed [25:0] gap;
  logic signed [25:0] depth;
  logic [7:0]         g;
  logic [3:0]         wave_idx;
  logic signed [18:0] phase;
  logic               warn;

  always_comb begin
    offscreen = (32'(col) >= 32'(SCREEN_WIDTH)) || (32'(row) >= 32'(SCREEN_HEIGHT));
    surf      = 26'(cfg.floor_row) - 26'(cfg.view_row);
    row26     = $signed({18'b0, row});
    gap       = surf - H26;
    depth     = row26 - surf;
    g         = 8'(26'(WARN_RANGE) - gap);
    warn      = (gap < 26'sd240) && (row26 >= H26 - 26'sd4)
                && ((gap < 26'sd80) ? cfg.frame[3] : cfg.frame[4]);
    wave_idx  = row[4:1] + cfg.frame[5:2];
    phase     = $signed({11'b0, col}) + $signed({3'b0, cfg.left_col})
                + 19'(wave_of(wave_idx));

    cls.sum   = (28'(phase) * 28'sd5) + $signed({18'b0, row, 2'b0})
                + $signed({3'b0, cfg.frame, 1'b0}) + $signed({4'b0, cfg.frame});
    cls.deep  = depth > 26'sd48;
    cls.d16   = depth > 26'sd16;
    if (g >= 8'(4 * WARN_STEP))      cls.warn_n = 3'd5;
    else if (g >= 8'(3 * WARN_STEP)) cls.warn_n = 3'd4;
    else if (g >= 8'(2 * WARN_STEP)) cls.warn_n = 3'd3;
    else if (g >= 8'(WARN_STEP))     cls.warn_n = 3'd2;
    else                             cls.warn_n = 3'd1;

    if (!cfg.climb || offscreen) begin
      cls.heat_n = 6'd0;
    end else if (cfg.tier > 6'(TIER_FULL)) begin
      cls.heat_n = 6'(TIER_FULL);
    end else begin
      cls.heat_n = cfg.tier;
    end

    cls.kind = KIND_NONE;
    if (cfg.climb && !offscreen && cfg.lava) begin
      if (surf >= H26) begin
        if (warn) cls.kind = KIND_WARN;
      end else if (row26 >= surf) begin
        cls.kind = (depth < 26'sd2) ? KIND_CREST : KIND_BODY;
      end else if (row26 == surf - 26'sd1) begin
        cls.kind = KIND_GLOW;
      end
    end
  end

endmodule

// File: hw/rtl/lpob_blend_mul.sv
`timescale 1ns / 1ps
module lpob_blend_mul (
  input  logic [23:0]        a,
  input  logic [23:0]        b,
  input  logic [5:0]         n,
  input  lpob_pkg::div_t     d,
  output logic [2:0][13:0]   prod
);
  import lpob_pkg::*;

  logic [5:0] dn;

  always_comb begin
    dn = d_value(d) - n;
    for (int i = 0; i < 3; i++) begin
      prod[i] = 14'(a[8*i +: 8]) * 14'(dn) + 14'(b[8*i +: 8]) * 14'(n);
    end
  end

endmodule

// File: hw/rtl/lpob_blend_div.sv
`timescale 1ns / 1ps
module lpob_blend_div (
  input  logic [2:0][13:0] prod,
  input  lpob_pkg::div_t   d,
  output logic [23:0]      color
);
  import lpob_pkg::*;

  logic [19:0] p48 [3];
  logic [25:0] p5  [3];
  logic [25:0] p3  [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      p48[i] = 20'(prod[i][13:4]) * 20'd683;
      p5[i]  = 26'(prod[i]) * 26'd3277;
      p3[i]  = 26'(prod[i]) * 26'd2731;
      case (d)
        DIV48:   color[8*i +: 8] = p48[i][18:11];
        DIV3:    color[8*i +: 8] = p3[i][20:13];
        default: color[8*i +: 8] = p5[i][21:14];
      endcase
    end
  end

endmodule

// File: hw/rtl/lava_pixel_overlay_blender_unit.sv
`timescale 1ns / 1ps
// Lava pixel overlay blender.
// Input stream s_*: one pixel word per beat, tdata = {base_color, pixel_row, pixel_col}.
// Output stream m_*: one blended color word per input word, in order.
// Config: write cfg_data to register cfg_index when cfg_we is high; change registers
// only while the pipe is empty. Index 0 climb_mode_on, 1 difficulty_tier, 2 lava_on,
// 3 lava_floor_row, 4 view_top_row, 5 view_left_col, 6 frame_count.
// Pipeline: 5 register stages (classify, heat products plus bubble reciprocal multiply,
// heat divide plus tint select, lava products, lava divide); m_tvalid rises when the word
// leaves the lava divide stage, and the word is taken at an edge with m_tready high.
// Throughput: one pixel per clock while m_tready is high; every stage has its own valid bit.
// Each stage advances when it is empty or the stage after it advances, so bubbles
// close up and input is still taken while a result waits on m_tready.
// A stalled receiver backs the pipe up, and s_tready drops only when all five stages
// hold words. Nothing is lost or repeated.
// Reset (rst, synchronous) clears all valid bits and all config registers to 0.
module lava_pixel_overlay_blender_unit #(
  parameter int SCREEN_WIDTH  = lpob_pkg::SCREEN_WIDTH_DEF,
  parameter int SCREEN_HEIGHT = lpob_pkg::SCREEN_HEIGHT_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,  // pixel_col[7:0], pixel_row[15:8], base_color[39:16]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,  // out_color[23:0]
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [23:0] cfg_data
);
  import lpob_pkg::*;

  cfg_t cfg;
  cls_t cls_in;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_CLIMB: cfg.climb     <= cfg_data[0];
        REG_TIER:  cfg.tier      <= cfg_data[5:0];
        REG_LAVA:  cfg.lava      <= cfg_data[0];
        REG_FLOOR: cfg.floor_row <= $signed(cfg_data);
        REG_VIEW:  cfg.view_row  <= $signed(cfg_data);
        REG_LEFT:  cfg.left_col  <= cfg_data[15:0];
        REG_FRAME: cfg.frame     <= cfg_data;
        default:   ;
      endcase
    end
  end

  lpob_class #(
    .SCREEN_WIDTH (SCREEN_WIDTH),
    .SCREEN_HEIGHT(SCREEN_HEIGHT)
  ) u_class (
    .cfg(cfg),
    .col(s_tdata[7:0]),
    .row(s_tdata[15:8]),
    .cls(cls_in)
  );

  logic va, vb, vc, vd, ve;
  logic ra, rb, rc, rd, re;

  always_comb begin
    re = !ve || m_tready;
    rd = !vd || re;
    rc = !vc || rd;
    rb = !vb || rc;
    ra = !va || rb;
  end

  assign s_tready = ra;
  assign m_tvalid = ve;

  // stage A
  logic [23:0] a_pix;
  cls_t        a_cls;

  // stage B
  logic [2:0][13:0] b_prod_next;
  logic [2:0][13:0] b_prod;
  logic [54:0]      b_qprod;
  logic [20:0]      b_q;
  cls_t             b_cls;

  // stage C
  logic [23:0] c_pix_next;
  logic [26:0] rem;
  logic        bubble;
  logic [23:0] c_tint_next;
  logic [5:0]  c_n_next;
  div_t        c_d_next;
  logic [23:0] c_pix;
  logic [23:0] c_tint;
  logic [5:0]  c_n;
  div_t        c_d;

  // stage D
  logic [2:0][13:0] d_prod_next;
  logic [2:0][13:0] d_prod;
  div_t             d_d;

  logic [23:0] out_next;

  lpob_blend_mul u_heat_mul (
    .a(a_pix), .b(HEAT_TINT), .n(a_cls.heat_n), .d(DIV48), .prod(b_prod_next)
  );

  assign b_qprod = 55'(a_cls.sum[26:0]) * 55'(BUB_RECIP);

  lpob_blend_div u_heat_div (.prod(b_prod), .d(DIV48), .color(c_pix_next));

  always_comb begin
    rem    = b_cls.sum[26:0] - 27'({6'b0, b_q} * 27'(BUB_MOD));
    bubble = b_cls.sum[27] || (rem < 27'd3);
    c_tint_next = 24'd0;
    c_n_next    = 6'd0;
    c_d_next    = DIV5;
    case (b_cls.kind)
      KIND_WARN: begin
        c_tint_next = WARN_TINT;
        c_n_next    = 6'(b_cls.warn_n);
      end
      KIND_CREST: begin
        c_tint_next = CREST_TINT;
        c_n_next    = 6'd4;
      end
      KIND_BODY: begin
        c_tint_next = bubble ? CREST_TINT : (b_cls.deep ? DEEP_TINT : BODY_TINT);
        c_n_next    = b_cls.d16 ? 6'd4 : 6'd3;
      end
      KIND_GLOW: begin
        c_tint_next = GLOW_TINT;
        c_n_next    = 6'd1;
        c_d_next    = DIV3;
      end
      default: ;
    endcase
  end

  lpob_blend_mul u_lava_mul (
    .a(c_pix), .b(c_tint), .n(c_n), .d(c_d), .prod(d_prod_next)
  );

  lpob_blend_div u_lava_div (.prod(d_prod), .d(d_d), .color(out_next));

  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0;
      vb <= 1'b0;
      vc <= 1'b0;
      vd <= 1'b0;
      ve <= 1'b0;
    end else begin
      if (ra) va <= s_tvalid;
      if (rb) vb <= va;
      if (rc) vc <= vb;
      if (rd) vd <= vc;
      if (re) ve <= vd;
    end
  end

  always_ff @(posedge clk) begin
    if (ra) begin
      a_pix <= s_tdata[39:16];
      a_cls <= cls_in;
    end
    if (rb) begin
      b_prod <= b_prod_next;
      b_q    <= b_qprod[BUB_SHIFT +: 21];
      b_cls  <= a_cls;
    end
    if (rc) begin
      c_pix  <= c_pix_next;
      c_tint <= c_tint_next;
      c_n    <= c_n_next;
      c_d    <= c_d_next;
    end
    if (rd) begin
      d_prod <= d_prod_next;
      d_d    <= c_d;
    end
    if (re) begin
      m_tdata <= out_next;
    end
  end

  a_full_when_blocked: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> va && vb && vc && vd && ve)
    else $error("input blocked with an empty stage");

  a_lava_weight: assert property (@(posedge clk) disable iff (rst)
    vc |-> (c_n <= 6'd5) && (c_d != DIV3 || c_n <= 6'd1) && c_d != DIV48)
    else $error("lava blend weight out of range");

  a_deep_implies_d16: assert property (@(posedge clk) disable iff (rst)
    vb && b_cls.kind == KIND_BODY && b_cls.deep |-> b_cls.d16)
    else $error("depth flags inconsistent");

endmodule
